[hdl/pcsc_pkg.sv]
// Types, codes and constants shared by the pixel channel swizzle/convert block.
// Used by pcsc_lane and pixel_channel_swizzle_convert. No dependencies.
package pcsc_pkg;

  localparam int unsigned NUM_CH       = 4;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned SRC_LIM      = (MAX_CHANNELS < NUM_CH) ? MAX_CHANNELS : NUM_CH;

  localparam logic [7:0]  BYTE_MAX = 8'hFF;
  localparam logic [31:0] F32_ONE  = 32'h3F80_0000;
  localparam logic [63:0] F64_ONE  = 64'h3FF0_0000_0000_0000;

  typedef enum logic [1:0] {
    TY_BYTE = 2'd0,
    TY_F32  = 2'd1,
    TY_F64  = 2'd2
  } chan_type_e;

  typedef enum logic [2:0] {
    REG_SRC_TYPE  = 3'd0,
    REG_DST_TYPE  = 3'd1,
    REG_DST_COUNT = 3'd2,
    REG_CH_SEL    = 3'd3,
    REG_ALPHA     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_VAL  = 2'd0,
    OP_RND  = 2'd1,
    OP_BYTE = 2'd2
  } lane_op_e;

  typedef struct packed {
    logic        konst;
    logic [63:0] raw;
  } lane_in_t;

  typedef struct packed {
    lane_op_e    op;
    logic        wide;
    logic        sign;
    logic [63:0] val;
    logic        grd;
    logic        stk;
    logic        drop8;
    logic [6:0]  shamt;
  } stage_a_t;

  typedef struct packed {
    logic        to_byte;
    logic [63:0] val;
    logic [6:0]  shamt;
  } stage_b_t;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } lane_en_t;

  function automatic chan_type_e norm_type(input logic [1:0] t);
    chan_type_e r;
    case (t)
      TY_BYTE: r = TY_BYTE;
      TY_F32:  r = TY_F32;
      default: r = TY_F64;
    endcase
    return r;
  endfunction

endpackage

[hdl/pixel_channel_swizzle_convert.sv]
// Pixel channel swizzle and type converter, top level with register port.
// Depends on pcsc_pkg and pcsc_lane.
//
// Takes one pixel per clock and carries it, once accepted, through one
// selection stage, then three conversion stages per channel (decode and
// align, round, scale and saturate). Each stage holds its own valid bit and
// fills a bubble even while the output is stalled, so throughput is one
// pixel per cycle whenever dst_ready_i stays high. Registers at byte offsets
// 0x0 source type, 0x4 destination type, 0x8 channel count, 0xC channel
// select, 0x10 alpha mask; change them only while no pixel is in flight.
module pixel_channel_swizzle_convert import pcsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        src_valid_i,
  output logic        src_ready_o,
  input  logic [63:0] src_ch0_i,
  input  logic [63:0] src_ch1_i,
  input  logic [63:0] src_ch2_i,
  input  logic [63:0] src_ch3_i,
  output logic        dst_valid_o,
  input  logic        dst_ready_i,
  output logic [63:0] dst_ch0_o,
  output logic [63:0] dst_ch1_o,
  output logic [63:0] dst_ch2_o,
  output logic [63:0] dst_ch3_o
);

  logic [1:0]  src_type_q;
  logic [1:0]  dst_type_q;
  logic [2:0]  dest_count_q;
  logic [11:0] ch_sel_q;
  logic [3:0]  alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_type_q   <= 2'd0;
      dst_type_q   <= 2'd0;
      dest_count_q <= 3'd4;
      ch_sel_q     <= 12'd1672;
      alpha_q      <= 4'd8;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_SRC_TYPE:  src_type_q   <= pwdata[1:0];
        REG_DST_TYPE:  dst_type_q   <= pwdata[1:0];
        REG_DST_COUNT: dest_count_q <= pwdata[2:0];
        REG_CH_SEL:    ch_sel_q     <= pwdata[11:0];
        REG_ALPHA:     alpha_q      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SRC_TYPE:  prdata = {30'b0, src_type_q};
      REG_DST_TYPE:  prdata = {30'b0, dst_type_q};
      REG_DST_COUNT: prdata = {29'b0, dest_count_q};
      REG_CH_SEL:    prdata = {20'b0, ch_sel_q};
      REG_ALPHA:     prdata = {28'b0, alpha_q};
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  chan_type_e st, dt;
  logic [2:0] cnt;

  assign st  = norm_type(src_type_q);
  assign dt  = norm_type(dst_type_q);
  assign cnt = (dest_count_q > 3'(NUM_CH)) ? 3'(NUM_CH) : dest_count_q;

  logic     v0_q, va_q, vb_q, vc_q;
  logic     en_0, en_a, en_b, en_c;
  lane_en_t lane_en;

  assign en_c = !vc_q || dst_ready_i;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign en_0 = !v0_q || en_a;
  assign lane_en = '{a: en_a, b: en_b, c: en_c};

  // advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_0) v0_q <= src_valid_i;
      if (en_a) va_q <= v0_q;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  assign src_ready_o = en_0;
  assign dst_valid_o = vc_q;

  logic [63:0] src [NUM_CH];
  logic [63:0] dst [NUM_CH];

  assign src[0] = src_ch0_i;
  assign src[1] = src_ch1_i;
  assign src[2] = src_ch2_i;
  assign src[3] = src_ch3_i;

  for (genvar gi = 0; gi < NUM_CH; gi++) begin : g_lane
    logic [2:0]  chsel;
    logic [63:0] fill;
    lane_in_t    sel_d, sel_q;

    assign chsel = ch_sel_q[3*gi +: 3];

    always_comb begin
      if (!alpha_q[gi])      fill = '0;
      else if (dt == TY_BYTE) fill = {56'b0, BYTE_MAX};
      else if (dt == TY_F32)  fill = {32'b0, F32_ONE};
      else                    fill = F64_ONE;
    end

    always_comb begin
      if (3'(gi) >= cnt) begin
        sel_d = '{konst: 1'b1, raw: '0};
      end else if (chsel >= 3'(SRC_LIM)) begin
        sel_d = '{konst: 1'b1, raw: fill};
      end else begin
        sel_d = '{konst: 1'b0, raw: src[chsel[1:0]]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_0) sel_q <= sel_d;
    end

    pcsc_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .in_i  (sel_q),
      .st_i  (st),
      .dt_i  (dt),
      .dst_o (dst[gi])
    );
  end

  assign dst_ch0_o = dst[0];
  assign dst_ch1_o = dst[1];
  assign dst_ch2_o = dst[2];
  assign dst_ch3_o = dst[3];

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src_valid_i && src_ready_o) |=> v0_q)
    else $error("accepted word not captured");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !src_ready_o |-> (v0_q && va_q && vb_q && vc_q))
    else $error("input stalled with a bubble in the pipe");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dst_valid_o && dest_count_q < 3'd4) |-> (dst_ch3_o == '0))
    else $error("unused channel not zero");

  a_byte_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dst_valid_o && dst_type_q == TY_BYTE) |-> (dst_ch0_o[63:8] == '0))
    else $error("byte word has high bits set");
`endif

endmodule

[hdl/pcsc_lane.sv]
// One destination channel: three register stages of type conversion
// (decode and align, round, scale and saturate). Depends on pcsc_pkg.
module pcsc_lane import pcsc_pkg::*; (
  input  logic        clk_i,
  input  lane_en_t    en_i,
  input  lane_in_t    in_i,
  input  chan_type_e  st_i,
  input  chan_type_e  dt_i,
  output logic [63:0] dst_o
);

  stage_a_t    a_d, a_q;
  stage_b_t    b_d, b_q;
  logic [63:0] c_d, c_q;

  logic [7:0]   k;
  logic [2:0]   kp;
  logic [127:0] kshift;
  logic [31:0]  b32;
  logic [7:0]   e32;
  logic [22:0]  f32;
  logic [4:0]   fp;
  logic [51:0]  sub_frac;
  logic [31:0]  prod32;
  logic         nan32;
  logic [10:0]  e64;
  logic [51:0]  f64;
  logic [60:0]  prod64;
  logic         nan64;
  logic [6:0]   sub_sh;
  logic [116:0] sub_ext;

  assign k      = in_i.raw[7:0];
  assign b32    = in_i.raw[31:0];
  assign e32    = b32[30:23];
  assign f32    = b32[22:0];
  assign nan32  = (e32 == 8'hFF) && (f32 != '0);
  assign e64    = in_i.raw[62:52];
  assign f64    = in_i.raw[51:0];
  assign nan64  = (e64 == 11'h7FF) && (f64 != '0);

  always_comb begin
    kp = '0;
    for (int j = 0; j < 8; j++) begin
      if (k[j]) kp = 3'(j);
    end
    fp = '0;
    for (int j = 0; j < 23; j++) begin
      if (f32[j]) fp = 5'(j);
    end
  end

  assign kshift   = {16{k}} << (4'd8 - {1'b0, kp});
  assign sub_frac = {29'b0, f32} << (6'd52 - {1'b0, fp});
  assign prod32   = {1'b1, f32, 8'b0} - {8'b0, 1'b1, f32};
  assign prod64   = {1'b1, f64, 8'b0} - {8'b0, 1'b1, f64};
  assign sub_sh   = (e64 < 11'd871) ? 7'd55 : 7'(11'd926 - e64);
  assign sub_ext  = {1'b1, f64, 64'b0} >> sub_sh;

  // decode and align
  always_comb begin
    a_d    = '0;
    a_d.op = OP_VAL;
    if (in_i.konst) begin
      a_d.val = in_i.raw;
    end else begin
      case (st_i)
        TY_BYTE: begin
          if (dt_i == TY_BYTE) begin
            a_d.val = {56'b0, k};
          end else if (k == 8'd0) begin
            a_d.val = '0;
          end else if (k == BYTE_MAX) begin
            a_d.val = (dt_i == TY_F32) ? {32'b0, F32_ONE} : F64_ONE;
          end else begin
            a_d.op  = OP_RND;
            a_d.stk = 1'b1;
            if (dt_i == TY_F32) begin
              a_d.val = {33'b0, 8'd119 + 8'(kp), kshift[127:105]};
              a_d.grd = kshift[104];
            end else begin
              a_d.wide = 1'b1;
              a_d.val  = {1'b0, 11'd1015 + 11'(kp), kshift[127:76]};
              a_d.grd  = kshift[75];
            end
          end
        end
        TY_F32: begin
          case (dt_i)
            TY_F32: a_d.val = {32'b0, b32};
            TY_BYTE: begin
              if (nan32 || b32[31] || e32 == 8'd0) begin
                a_d.val = '0;
              end else if (e32 >= 8'd135) begin
                a_d.val = {56'b0, BYTE_MAX};
              end else begin
                a_d.op    = OP_BYTE;
                a_d.val   = {32'b0, prod32};
                a_d.drop8 = prod32[31];
                a_d.shamt = (e32 < 8'd23) ? 7'd127 : 7'(8'd150 - e32);
              end
            end
            default: begin
              if (nan32) begin
                a_d.val = {b32[31], 11'h7FF, f32 | 23'h40_0000, 29'b0};
              end else if (e32 == 8'hFF) begin
                a_d.val = {b32[31], 11'h7FF, 52'b0};
              end else if (e32 == 8'd0) begin
                if (f32 == '0) a_d.val = {b32[31], 63'b0};
                else           a_d.val = {b32[31], 11'd874 + 11'(fp), sub_frac};
              end else begin
                a_d.val = {b32[31], 11'd896 + 11'(e32), f32, 29'b0};
              end
            end
          endcase
        end
        default: begin
          case (dt_i)
            TY_F64: a_d.val = in_i.raw;
            TY_BYTE: begin
              if (nan64 || in_i.raw[63] || e64 == 11'd0) begin
                a_d.val = '0;
              end else if (e64 >= 11'd1031) begin
                a_d.val = {56'b0, BYTE_MAX};
              end else begin
                a_d.op    = OP_BYTE;
                a_d.val   = {3'b0, prod64};
                a_d.drop8 = prod64[60];
                a_d.shamt = (e64 < 11'd948) ? 7'd127 : 7'(11'd1075 - e64);
              end
            end
            default: begin
              a_d.sign = in_i.raw[63];
              if (nan64) begin
                a_d.val = {32'b0, in_i.raw[63], 8'hFF, f64[51:29] | 23'h40_0000};
              end else if (e64 == 11'h7FF || e64 >= 11'd1151) begin
                a_d.val = {32'b0, in_i.raw[63], 8'hFF, 23'b0};
              end else if (e64 == 11'd0) begin
                a_d.val = {32'b0, in_i.raw[63], 31'b0};
              end else if (e64 >= 11'd897) begin
                a_d.op  = OP_RND;
                a_d.val = {33'b0, 8'(e64 - 11'd896), f64[51:29]};
                a_d.grd = f64[28];
                a_d.stk = |f64[27:0];
              end else begin
                a_d.op  = OP_RND;
                a_d.val = {41'b0, sub_ext[86:64]};
                a_d.grd = sub_ext[63];
                a_d.stk = |sub_ext[62:0];
              end
            end
          endcase
        end
      endcase
    end
  end

  // round to nearest even
  logic [63:0] bkept;
  logic [63:0] bsum;
  logic        bgrd;
  logic        bstk;
  logic        binc;

  always_comb begin
    if (a_q.op == OP_BYTE) begin
      bkept = a_q.drop8 ? (a_q.val >> 8) : (a_q.val >> 7);
      bgrd  = a_q.drop8 ? a_q.val[7] : a_q.val[6];
      bstk  = a_q.drop8 ? (|a_q.val[6:0]) : (|a_q.val[5:0]);
    end else begin
      bkept = a_q.val;
      bgrd  = a_q.grd;
      bstk  = a_q.stk;
    end
    binc = bgrd & (bstk | bkept[0]);
    bsum = bkept + 64'(binc);
    b_d.to_byte = (a_q.op == OP_BYTE);
    b_d.shamt   = a_q.shamt;
    case (a_q.op)
      OP_BYTE: b_d.val = a_q.drop8 ? (bsum << 8) : (bsum << 7);
      OP_RND:  b_d.val = a_q.wide ? {a_q.sign, bsum[62:0]}
                                  : {32'b0, a_q.sign, bsum[30:0]};
      default: b_d.val = a_q.val;
    endcase
  end

  // scale and saturate
  logic [63:0] cq;

  always_comb begin
    cq = b_q.val >> b_q.shamt;
    if (b_q.to_byte) c_d = (|cq[63:8]) ? {56'b0, BYTE_MAX} : {56'b0, cq[7:0]};
    else             c_d = b_q.val;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) a_q <= a_d;
    if (en_i.b) b_q <= b_d;
    if (en_i.c) c_q <= c_d;
  end

  assign dst_o = c_q;

endmodule
